FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Hold a consequence in the cycle after an antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/eat_pkg.sv
`timescale 1ns / 1ps

package eat_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PART_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HELD_W   = 7;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Register index carried in paddr[2].
  localparam logic REG_WANTED_PARTITION = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  // Control half of the query word that walks the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

  // Handshake control from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic launch;
    logic out_load;
  } ctrl_t;

endpackage

FILE: rtl/earliest_arrival_table_unit.sv
`timescale 1ns / 1ps
// Timing: a clear or load word goes straight to the output register; a query word first
//   walks the full row of cells, one register per cell, and its result is then registered.
// Throughput: one word at a time; a clear or load every cycle while the output register
//   is free or being emptied; no new word is taken while a query walks the cells.
// Reset: entry count, flex option, partition register and handshake state clear at once;
//   the entry cells are left as they are and only entries below the count are used.

module earliest_arrival_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB-style configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [eat_pkg::ADDR_W-1:0]            paddr,
  input  logic [eat_pkg::DATA_W-1:0]            pwdata,
  output logic [eat_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [eat_pkg::KIND_W-1:0]            kind_i,
  input  logic [TIME_BITS-1:0]                  depart_or_query_time_i,
  input  logic [TIME_BITS-1:0]                  arrive_time_i,
  input  logic                                  is_flex_i,
  input  logic [eat_pkg::PART_W-1:0]            option_partition_i,
  input  logic [TIME_BITS-1:0]                  flex_length_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  found_o,
  output logic [TIME_BITS:0]                    earliest_arrival_o,
  output logic [eat_pkg::STATUS_W-1:0]          status_o,
  output logic [eat_pkg::HELD_W-1:0]            entries_held_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [eat_pkg::PART_W-1:0] wanted_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == eat_pkg::REG_WANTED_PARTITION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= '0;
    end else if (cfg_wr) begin
      wanted_q <= pwdata[eat_pkg::PART_W-1:0];
    end
  end

  // Unknown register addresses read as zero.
  assign prdata = (paddr[2] == eat_pkg::REG_WANTED_PARTITION)
                  ? {{(eat_pkg::DATA_W - eat_pkg::PART_W){1'b0}}, wanted_q} : '0;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  eat_pkg::ctrl_t ctl;
  logic           is_query, tok_done, acc;

  assign is_query = (kind_i == eat_pkg::KIND_QUERY);

  eat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .is_query_i  (is_query),
    .tok_done_i  (tok_done),
    .ctl_o       (ctl)
  );

  assign in_ready_o = ctl.in_ready;
  assign acc        = in_valid_i && ctl.in_ready;

  // ---------------------------------------------------------------------------
  // Table control state: entry count and flex option
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       flex_q, flex_d;
  logic [TIME_BITS-1:0]       flex_min_q, flex_min_d;
  logic                       tbl_full, store;
  logic [eat_pkg::STATUS_W-1:0] status_now;

  assign tbl_full = (cnt_q >= CNT_W'(TABLE_DEPTH));

  // Partition mismatch takes precedence over a full table.
  always_comb begin
    status_now = eat_pkg::STATUS_OK;
    store      = 1'b0;
    if ((kind_i == eat_pkg::KIND_LOAD) && !is_flex_i) begin
      priority if (option_partition_i != wanted_q) begin
        status_now = eat_pkg::STATUS_MISMATCH;
      end else if (tbl_full) begin
        status_now = eat_pkg::STATUS_FULL;
      end else begin
        store = acc;
      end
    end
  end

  // Queries, dropped loads and the unused kind leave the state alone.
  always_comb begin
    cnt_d      = cnt_q;
    flex_d     = flex_q;
    flex_min_d = flex_min_q;
    if (acc) begin
      if (kind_i == eat_pkg::KIND_CLEAR) begin
        cnt_d      = '0;
        flex_d     = 1'b0;
        flex_min_d = '0;
      end else if ((kind_i == eat_pkg::KIND_LOAD) && is_flex_i) begin
        // Lower the flex minimum; the first flex option always sets it.
        if (!flex_q || (flex_length_i < flex_min_q)) flex_min_d = flex_length_i;
        flex_d = 1'b1;
      end else if (store) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      flex_q     <= 1'b0;
      flex_min_q <= '0;
    end else begin
      cnt_q      <= cnt_d;
      flex_q     <= flex_d;
      flex_min_q <= flex_min_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: each cell holds one (departure, arrival) entry. A query word
  // enters the first cell, advances one cell per cycle and carries the
  // running minimum arrival along.
  // ---------------------------------------------------------------------------
  eat_pkg::tok_ctl_t    tok_c  [0:TABLE_DEPTH];
  logic [TIME_BITS-1:0] t_c    [0:TABLE_DEPTH];
  logic [TIME_BITS:0]   best_c [0:TABLE_DEPTH];

  // Seed the query word with the flex option when one is present.
  assign tok_c[0].valid = ctl.launch;
  assign tok_c[0].found = flex_q;
  assign t_c[0]         = depart_or_query_time_i;
  assign best_c[0]      = flex_q ? ({1'b0, depart_or_query_time_i} + {1'b0, flex_min_q}) : '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    eat_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (store && (cnt_q == CNT_W'(g))),
      .wr_dep_i (depart_or_query_time_i),
      .wr_arr_i (arrive_time_i),
      .active_i (cnt_q > CNT_W'(g)),
      .tok_i    (tok_c[g]),
      .t_i      (t_c[g]),
      .best_i   (best_c[g]),
      .tok_o    (tok_c[g+1]),
      .t_o      (t_c[g+1]),
      .best_o   (best_c[g+1])
    );
  end

  assign tok_done = tok_c[TABLE_DEPTH].valid;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CNT_W+6:0]             held_ext;
  logic                         found_q;
  logic [TIME_BITS:0]           arr_q;
  logic [eat_pkg::STATUS_W-1:0] status_q;
  logic [eat_pkg::HELD_W-1:0]   held_q;

  // Report the count after the word, masked to the field width.
  assign held_ext = {7'd0, cnt_d};

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      if (tok_done) begin
        found_q  <= tok_c[TABLE_DEPTH].found;
        arr_q    <= tok_c[TABLE_DEPTH].found ? best_c[TABLE_DEPTH] : '0;
        status_q <= eat_pkg::STATUS_OK;
      end else begin
        found_q  <= 1'b0;
        arr_q    <= '0;
        status_q <= status_now;
      end
      held_q <= held_ext[eat_pkg::HELD_W-1:0];
    end
  end

  assign out_valid_o        = ctl.out_valid;
  assign found_o            = found_q;
  assign earliest_arrival_o = arr_q;
  assign status_o           = status_q;
  assign entries_held_o     = held_q;

endmodule

FILE: rtl/eat_cell.sv
`timescale 1ns / 1ps

module eat_cell #(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [TIME_BITS-1:0] wr_dep_i,
  input  logic [TIME_BITS-1:0] wr_arr_i,
  input  logic                 active_i,
  input  eat_pkg::tok_ctl_t    tok_i,
  input  logic [TIME_BITS-1:0] t_i,
  input  logic [TIME_BITS:0]   best_i,
  output eat_pkg::tok_ctl_t    tok_o,
  output logic [TIME_BITS-1:0] t_o,
  output logic [TIME_BITS:0]   best_o
);

  logic [TIME_BITS-1:0] dep_q, arr_q;
  eat_pkg::tok_ctl_t    tok_q, tok_d;
  logic [TIME_BITS-1:0] t_q;
  logic [TIME_BITS:0]   best_q, best_d;
  logic                 hit, take;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      dep_q <= wr_dep_i;
      arr_q <= wr_arr_i;
    end
  end

  // Entry qualifies if it is held and departs at or after the query time.
  always_comb begin
    hit         = active_i && (dep_q >= t_i);
    take        = hit && (!tok_i.found || ({1'b0, arr_q} < best_i));
    tok_d.valid = tok_i.valid;
    tok_d.found = tok_i.found | hit;
    best_d      = take ? {1'b0, arr_q} : best_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_i;
    best_q <= best_d;
  end

  assign tok_o  = tok_q;
  assign t_o    = t_q;
  assign best_o = best_q;

endmodule

FILE: rtl/eat_ctrl.sv
`timescale 1ns / 1ps

module eat_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  logic            is_query_i,
  input  logic            tok_done_i,
  output eat_pkg::ctrl_t  ctl_o
);

  eat_pkg::state_e state_q, state_d;
  logic            out_full_q, out_full_d;
  logic            acc;

  always_comb begin
    ctl_o.in_ready  = (state_q == eat_pkg::ST_IDLE) && (!out_full_q || out_ready_i);
    acc             = in_valid_i && ctl_o.in_ready;
    ctl_o.launch    = acc && is_query_i;
    ctl_o.out_load  = (acc && !is_query_i) || tok_done_i;
    ctl_o.out_valid = out_full_q;
    if (ctl_o.out_load) begin
      out_full_d = 1'b1;
    end else if (out_ready_i) begin
      out_full_d = 1'b0;
    end else begin
      out_full_d = out_full_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eat_pkg::ST_IDLE: begin
        if (ctl_o.launch) state_d = eat_pkg::ST_WALK;
      end
      eat_pkg::ST_WALK: begin
        if (tok_done_i) state_d = eat_pkg::ST_IDLE;
      end
      default: state_d = eat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= eat_pkg::ST_IDLE;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

endmodule

FILE: rtl/eat_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eat_checker #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 20
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         found_o,
  input logic [TIME_BITS:0]           earliest_arrival_o,
  input logic [eat_pkg::STATUS_W-1:0] status_o,
  input logic [eat_pkg::HELD_W-1:0]   entries_held_o
);

  localparam logic [eat_pkg::HELD_W-1:0] HELD_FULL = eat_pkg::HELD_W'(TABLE_DEPTH);

  // A waiting result word holds until taken.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(found_o) && $stable(earliest_arrival_o) && $stable(status_o) && $stable(entries_held_o), "result word changed while stalled")

  // Nothing found reports a zero arrival.
  `ASSERT_ALWAYS(a_zero_miss, clk_i, rst_ni, !(out_valid_o && !found_o) || (earliest_arrival_o == '0), "arrival nonzero without a hit")

  // A load status never comes with a query hit.
  `ASSERT_ALWAYS(a_status_excl, clk_i, rst_ni, !(out_valid_o && (status_o != eat_pkg::STATUS_OK)) || !found_o, "load status reported with a hit")

  // A drop for a full table reports a full count.
  `ASSERT_ALWAYS(a_full_count, clk_i, rst_ni, !(out_valid_o && (status_o == eat_pkg::STATUS_FULL)) || (entries_held_o == HELD_FULL), "full drop with a partial count")

endmodule

bind earliest_arrival_table_unit eat_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .TIME_BITS   (TIME_BITS)
) u_eat_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .found_o            (found_o),
  .earliest_arrival_o (earliest_arrival_o),
  .status_o           (status_o),
  .entries_held_o     (entries_held_o)
);
